// ----- src/rdru_pkg.sv -----
// ---------------------------------------------------------------------------
// rdru_pkg: shared definitions of the divide and remainder unit
// Operation codes, widths, sequencer states and the control structs that
// pass between the top level and the iterative divider.
// ---------------------------------------------------------------------------
package rdru_pkg;

	localparam int XLEN   = 32;
	localparam int ITER_W = $clog2(XLEN);
	localparam int KIND_W = 3;
	localparam int CNT_W  = 3;

	localparam int DIV_LATENCY_DEF = 3;
	localparam int REM_LATENCY_DEF = 4;

	localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DIV  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DIVU = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REM  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMU = 3'd4;

	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_ABS_A,
		DIV_ABS_B,
		DIV_ITER,
		DIV_FIX
	} div_state_t;

	typedef struct packed {
		logic start;
		logic is_signed;
		logic is_div;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- src/rdru_divider.sv -----
// ---------------------------------------------------------------------------
// rdru_divider: iterative restoring divider
// One shared subtractor takes the operand magnitudes, produces one quotient
// bit per cycle and applies the final sign, under a small sequencer.
// ---------------------------------------------------------------------------
module rdru_divider import rdru_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  div_cmd_t        cmd,
	input  logic [XLEN-1:0] dividend,
	input  logic [XLEN-1:0] divisor,
	output div_stat_t       stat,
	output logic [XLEN-1:0] result
);

	div_state_t        state_q, state_next;
	logic [ITER_W-1:0] iter_q;
	logic [XLEN-1:0]   rem_q;
	logic [XLEN-1:0]   quo_q;
	logic [XLEN-1:0]   b_q;
	logic              a_neg_q;
	logic              b_neg_q;
	logic              is_div_q;
	logic              b_zero_q;

	logic [XLEN+1:0]   op_a;
	logic [XLEN+1:0]   op_b;
	logic [XLEN+1:0]   diff;
	logic              borrow;
	logic [XLEN-1:0]   fix_val;
	logic              fix_neg;

	assign diff    = op_a - op_b;
	assign borrow  = diff[XLEN+1];
	assign fix_val = is_div_q ? quo_q : rem_q;
	assign fix_neg = is_div_q ? (a_neg_q ^ b_neg_q) : a_neg_q;

	always_comb begin
		state_next = state_q;
		op_a       = '0;
		op_b       = '0;
		stat.busy  = (state_q != DIV_IDLE);
		stat.done  = 1'b0;
		result     = '0;
		unique case (state_q)
			DIV_IDLE: begin
				if (cmd.start) begin
					state_next = DIV_ABS_A;
				end
			end
			DIV_ABS_A: begin
				op_b       = {2'b00, quo_q};
				state_next = DIV_ABS_B;
			end
			DIV_ABS_B: begin
				op_b       = {2'b00, b_q};
				state_next = DIV_ITER;
			end
			DIV_ITER: begin
				op_a = {1'b0, rem_q, quo_q[XLEN-1]};
				op_b = {2'b00, b_q};
				if (iter_q == '0) begin
					state_next = DIV_FIX;
				end
			end
			DIV_FIX: begin
				op_b       = {2'b00, fix_val};
				stat.done  = 1'b1;
				state_next = DIV_IDLE;
				if (is_div_q && b_zero_q) begin
					result = '1;
				end else if (fix_neg) begin
					result = diff[XLEN-1:0];
				end else begin
					result = fix_val;
				end
			end
			default: begin
				state_next = DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == DIV_IDLE) begin
				iter_q <= ITER_W'(XLEN - 1);
			end else if (state_q == DIV_ITER) begin
				iter_q <= iter_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				if (cmd.start) begin
					quo_q    <= dividend;
					b_q      <= divisor;
					rem_q    <= '0;
					a_neg_q  <= cmd.is_signed & dividend[XLEN-1];
					b_neg_q  <= cmd.is_signed & divisor[XLEN-1];
					is_div_q <= cmd.is_div;
					b_zero_q <= (divisor == '0);
				end
			end
			DIV_ABS_A: begin
				if (a_neg_q) begin
					quo_q <= diff[XLEN-1:0];
				end
			end
			DIV_ABS_B: begin
				if (b_neg_q) begin
					b_q <= diff[XLEN-1:0];
				end
			end
			DIV_ITER: begin
				if (borrow) begin
					rem_q <= {rem_q[XLEN-2:0], quo_q[XLEN-1]};
				end else begin
					rem_q <= diff[XLEN-1:0];
				end
				quo_q <= {quo_q[XLEN-2:0], ~borrow};
			end
			DIV_FIX: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/riscv_divide_remainder_unit.sv -----
// ---------------------------------------------------------------------------
// riscv_divide_remainder_unit: RV32 divide and remainder unit
// Takes one request per transfer and returns one result per transfer, with a
// fixed busy time counted in transfers and RISC-V M-extension semantics.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     kind, dividend, divisor
//   output    out_valid / out_stall   done_res, result
//
// A transfer that starts a divide or remainder holds off further input while
// the divider is busy, producing one quotient bit per cycle; every other
// transfer leaves the divider idle.
// Reset clears the busy count and the output valid; no clearing pass.
// A stalled output holds the next input transfer until the result is taken.
// ---------------------------------------------------------------------------
module riscv_divide_remainder_unit import rdru_pkg::*; #(
	parameter int DIV_LATENCY = DIV_LATENCY_DEF,
	parameter int REM_LATENCY = REM_LATENCY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [XLEN-1:0]   dividend,
	input  logic [XLEN-1:0]   divisor,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              done_res,
	output logic [XLEN-1:0]   result
);

	logic [CNT_W-1:0] busy_count_q;
	logic [XLEN-1:0]  held_result_q;
	logic             out_valid_q;
	logic             done_res_q;
	logic [XLEN-1:0]  result_q;

	logic             accept;
	logic             is_op;
	logic             is_signed;
	logic             is_div;
	div_cmd_t         div_cmd;
	div_stat_t        div_stat;
	logic [XLEN-1:0]  div_result;

	assign in_stall = div_stat.busy | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		is_op     = 1'b1;
		is_signed = 1'b0;
		is_div    = 1'b0;
		unique case (kind)
			KIND_DIV: begin
				is_signed = 1'b1;
				is_div    = 1'b1;
			end
			KIND_DIVU: begin
				is_div = 1'b1;
			end
			KIND_REM: begin
				is_signed = 1'b1;
			end
			KIND_REMU: begin
			end
			default: begin
				is_op = 1'b0;
			end
		endcase
	end

	assign div_cmd.start     = accept & is_op & (busy_count_q == '0);
	assign div_cmd.is_signed = is_signed;
	assign div_cmd.is_div    = is_div;

	rdru_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_stat),
		.result   (div_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (busy_count_q != '0) begin
					busy_count_q <= busy_count_q - 1'b1;
				end else if (is_op) begin
					busy_count_q <= is_div ? CNT_W'(DIV_LATENCY) : CNT_W'(REM_LATENCY);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_stat.done) begin
			held_result_q <= div_result;
		end
		if (accept) begin
			if (busy_count_q == CNT_W'(1)) begin
				done_res_q <= 1'b1;
				result_q   <= held_result_q;
			end else begin
				done_res_q <= 1'b0;
				result_q   <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign done_res  = done_res_q;
	assign result    = result_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the RV32 divide and remainder unit
// A queue of requests feeds a clocked driver, and a clocked monitor takes the
// results under random stall. Every accepted transfer is run through a
// transfer-level model of the busy counter and the M-extension arithmetic, and
// each result transfer is checked against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
	import rdru_pkg::*;

	localparam logic [KIND_W-1:0] KIND_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic [XLEN-1:0]   a;
		logic [XLEN-1:0]   b;
		logic              drain;
	} div_request_t;

	typedef struct packed {
		logic            done;
		logic [XLEN-1:0] value;
	} div_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] kind = KIND_NONE;
	logic [XLEN-1:0]   dividend = '0;
	logic [XLEN-1:0]   divisor = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              done_res;
	logic [XLEN-1:0]   result;

	div_request_t request_queue[$];
	div_outcome_t expected_results[$];
	div_request_t next_req;
	div_outcome_t want;

	logic [CNT_W-1:0] busy_left = '0;
	logic [XLEN-1:0]  held_value = '0;
	logic             done_now = 1'b0;

	int unsigned sent_cnt = 0;
	int unsigned got_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned n_div = 0;
	int unsigned n_rem = 0;
	int unsigned n_zero = 0;
	int unsigned n_overflow = 0;
	int unsigned n_ignored = 0;

	riscv_divide_remainder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.done_res  (done_res),
		.result    (result)
	);

	function automatic logic [XLEN-1:0] m_ext_result(logic [KIND_W-1:0] op,
			logic [XLEN-1:0] a, logic [XLEN-1:0] b);
		logic   sgn;
		logic   quot;
		longint sa;
		longint sb;
		longint r;
		sgn = (op == KIND_DIV) || (op == KIND_REM);
		quot = (op == KIND_DIV) || (op == KIND_DIVU);
		sa = sgn ? longint'($signed(a)) : longint'(a);
		sb = sgn ? longint'($signed(b)) : longint'(b);
		if (sb == 0) begin
			r = quot ? -1 : sa;
		end else begin
			r = quot ? sa / sb : sa % sb;
		end
		return r[XLEN-1:0];
	endfunction

	// One accepted transfer is one tick of the unit.
	function automatic div_outcome_t divider_tick(logic [KIND_W-1:0] op,
			logic [XLEN-1:0] a, logic [XLEN-1:0] b);
		div_outcome_t o;
		if (busy_left != 0) begin
			busy_left = busy_left - 1'b1;
			if (busy_left == 0)
				done_now = 1'b1;
			if (op >= KIND_DIV && op <= KIND_REMU)
				n_ignored++;
		end else if (op >= KIND_DIV && op <= KIND_REMU) begin
			done_now = 1'b0;
			held_value = m_ext_result(op, a, b);
			if (op <= KIND_DIVU) begin
				busy_left = CNT_W'(DIV_LATENCY_DEF);
				n_div++;
			end else begin
				busy_left = CNT_W'(REM_LATENCY_DEF);
				n_rem++;
			end
			if (b == '0)
				n_zero++;
			if ((op == KIND_DIV || op == KIND_REM) && a == 32'h8000_0000 && b == '1)
				n_overflow++;
			if (busy_left == 0)
				done_now = 1'b1;
		end else begin
			done_now = 1'b0;
			held_value = '0;
		end
		o.done = done_now;
		o.value = done_now ? held_value : '0;
		return o;
	endfunction

	function automatic logic [XLEN-1:0] pick_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return XLEN'($urandom_range(15));
			6: return -XLEN'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	task automatic add_request(logic [KIND_W-1:0] op, logic [XLEN-1:0] a,
			logic [XLEN-1:0] b, logic drain);
		div_request_t req;
		req.op = op;
		req.a = a;
		req.b = b;
		req.drain = drain;
		request_queue.push_back(req);
	endtask

	// A start followed by the ticks it keeps the unit busy, filled with
	// arbitrary requests that must be ignored.
	task automatic add_start_sequence(logic [KIND_W-1:0] op, logic [XLEN-1:0] a,
			logic [XLEN-1:0] b, logic drain);
		int unsigned ticks;
		ticks = (op <= KIND_DIVU) ? DIV_LATENCY_DEF : REM_LATENCY_DEF;
		add_request(op, a, b, drain);
		repeat (ticks)
			add_request(KIND_W'($urandom_range(KIND_MAX)), pick_operand(), pick_operand(),
				1'b0);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb_top: done, errors");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(divider_tick(kind, dividend, divisor));
				sent_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (request_queue.size() != 0
						&& !(request_queue[0].drain && expected_results.size() != 0)
						&& ((sent_cnt >= 700 && sent_cnt < 1000) || $urandom_range(99) >= 25)) begin
					next_req = request_queue.pop_front();
					kind <= next_req.op;
					dividend <= next_req.a;
					divisor <= next_req.b;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: done_res=%0b result=%h",
						done_res, result);
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (done_res !== want.done) begin
						$error("done_res: expected %0b, got %0b", want.done, done_res);
						fail_cnt++;
					end
					if (want.done && result !== want.value) begin
						$error("result: expected %h, got %h", want.value, result);
						fail_cnt++;
					end
				end
				got_cnt++;
			end
			out_stall <= !(got_cnt >= 200 && got_cnt < 500) && ($urandom_range(99) < 25);
		end
	end

	initial begin
		int unsigned      counted;
		int unsigned      idles;
		logic             mid_pause;
		logic [KIND_W-1:0] op;

		counted = 0;
		mid_pause = 1'b0;

		add_request(KIND_NONE, '0, '0, 1'b0);
		add_start_sequence(KIND_DIV, 32'h8000_0000, '1, 1'b0);
		add_start_sequence(KIND_REM, 32'h8000_0000, '1, 1'b0);
		add_start_sequence(KIND_DIVU, '1, '0, 1'b0);
		add_start_sequence(KIND_REM, 32'h8000_0000, '0, 1'b0);
		add_request(KIND_REMU + 3'd1, '1, '1, 1'b0);
		add_request(KIND_REMU + 3'd2, '0, '0, 1'b0);
		add_request(KIND_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_start_sequence(KIND_REMU, '1, 32'h7FFF_FFFF, 1'b0);

		while (counted < 1150) begin
			if ($urandom_range(99) < 80) begin
				op = KIND_W'($urandom_range(KIND_REMU, KIND_DIV));
				add_start_sequence(op, pick_operand(), pick_operand(),
					counted == 0 || (counted >= 600 && !mid_pause));
				if (counted >= 600)
					mid_pause = 1'b1;
				counted += (op <= KIND_DIVU) ? DIV_LATENCY_DEF + 1 : REM_LATENCY_DEF + 1;
				idles = $urandom_range(2);
				repeat (idles) begin
					if ($urandom_range(1))
						op = KIND_NONE;
					else
						op = KIND_W'($urandom_range(KIND_MAX, KIND_REMU + 3'd1));
					add_request(op, pick_operand(), pick_operand(), 1'b0);
					counted++;
				end
			end else begin
				add_request(KIND_W'($urandom_range(KIND_MAX)), pick_operand(), pick_operand(),
					1'b0);
				counted++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("tb_top: %0d transfers in, %0d results checked, %0d mismatches",
			sent_cnt, got_cnt, fail_cnt);
		$display("tb_top: %0d divides, %0d remainders, %0d by zero, %0d overflow, %0d ignored",
			n_div, n_rem, n_zero, n_overflow, n_ignored);
		if (fail_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
